// ----- design/mau_pkg.sv -----
package mau_pkg;

  localparam int MOD_BITS = 24;
  localparam int A_W = 28;
  localparam int B_W = 27;
  localparam int DIV_W = (A_W > MOD_BITS) ? A_W : MOD_BITS;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_MUL    = 3'd3,
    OP_QUO    = 3'd4,
    OP_RECIP  = 3'd5,
    OP_POW    = 3'd6,
    OP_REDUCE = 3'd7
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic signed [A_W-1:0] operand_a;
    logic [B_W-1:0]        operand_b;
  } req_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] result;
    logic                error;
  } rsp_t;

  typedef enum logic [1:0] {
    DS_A   = 2'd0,
    DS_B   = 2'd1,
    DS_EUC = 2'd2
  } div_src_t;

  typedef enum logic [2:0] {
    MS_AB   = 3'd0,
    MS_TQ   = 3'd1,
    MS_AINV = 3'd2,
    MS_ACC  = 3'd3,
    MS_SQ   = 3'd4
  } mul_src_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_src_t div_sel;
    logic     a_load;
    logic     b_load;
    logic     mul_start;
    mul_src_t mul_sel;
    logic     res_simple;
    logic     err_set;
    logic     euc_init;
    logic     euc_rem;
    logic     euc_step;
    logic     res_inv;
    logic     res_mul;
    logic     pow_one;
    logic     pow_init;
    logic     acc_load;
    logic     base_load;
    logic     res_acc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic div_done;
    logic mul_done;
    op_t  op;
    logic braw_zero;
    logic b_zero;
    logic rtmp_zero;
    logic r1_one;
    logic e_bit0;
    logic e_last;
  } sts_t;

endpackage

// ----- design/mau_div.sv -----
module mau_div
  import mau_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [MOD_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quot,
  output logic [MOD_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    dq;
  logic [MOD_BITS-1:0] rm;
  logic [MOD_BITS-1:0] dvs;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;
  logic                ge;

  assign trial = {rm, dq[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      done <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rm  <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rm <= ge ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
      dq <= {dq[DIV_W-2:0], ge};
    end
  end

  assign quot = dq;
  assign rem  = rm;

endmodule

// ----- design/mau_mulmod.sv -----
module mau_mulmod
  import mau_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MOD_BITS-1:0] x,
  input  logic [MOD_BITS-1:0] y,
  input  logic [MOD_BITS-1:0] m,
  output logic                done,
  output logic [MOD_BITS-1:0] p
);

  localparam int CNT_W = $clog2(MOD_BITS);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] xs;
  logic [MOD_BITS-1:0] ys;
  logic [MOD_BITS-1:0] ms;
  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS:0]   dbl_red;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS:0]   sum_red;

  assign dbl     = {acc, 1'b0};
  assign dbl_red = (dbl >= {1'b0, ms}) ? dbl - {1'b0, ms} : dbl;
  assign sum     = dbl_red + (ys[MOD_BITS-1] ? {1'b0, xs} : '0);
  assign sum_red = (sum >= {1'b0, ms}) ? sum - {1'b0, ms} : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      done <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(MOD_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xs  <= x;
      ys  <= y;
      ms  <= m;
    end else if (busy) begin
      acc <= sum_red[MOD_BITS-1:0];
      ys  <= {ys[MOD_BITS-2:0], 1'b0};
    end
  end

  assign p = acc;

endmodule

// ----- design/mau_dp.sv -----
module mau_dp
  import mau_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  req_t                req,
  input  logic [MOD_BITS-1:0] modulus,
  input  cmd_t                cmd,
  output sts_t                sts,
  output rsp_t                rsp
);

  op_t                   op;
  logic signed [A_W-1:0] a_raw;
  logic [B_W-1:0]        braw;
  logic [MOD_BITS-1:0]   a_res;
  logic [MOD_BITS-1:0]   b_res;
  logic [MOD_BITS-1:0]   r0;
  logic [MOD_BITS-1:0]   r1;
  logic [MOD_BITS-1:0]   rtmp;
  logic [MOD_BITS-1:0]   t0;
  logic [MOD_BITS-1:0]   t1;
  logic [MOD_BITS-1:0]   acc;
  logic [MOD_BITS-1:0]   base;
  logic [B_W-1:0]        e;
  logic [MOD_BITS-1:0]   res;
  logic                  err;
  rsp_t                  rsp_q;

  logic [A_W-1:0]      a_mag;
  logic [DIV_W-1:0]    dividend;
  logic [MOD_BITS-1:0] divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [MOD_BITS-1:0] div_rem;
  logic [MOD_BITS-1:0] mx;
  logic [MOD_BITS-1:0] my;
  logic                mul_done;
  logic [MOD_BITS-1:0] mul_p;
  logic [MOD_BITS-1:0] a_from_rem;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS:0]   sum_red;
  logic [MOD_BITS-1:0] simple;
  logic [MOD_BITS-1:0] t_new;

  assign a_mag = a_raw[A_W-1] ? (~$unsigned(a_raw)) + A_W'(1) : $unsigned(a_raw);

  always_comb begin
    unique case (cmd.div_sel)
      DS_B: begin
        dividend = DIV_W'(braw);
        divisor  = modulus;
      end
      DS_EUC: begin
        dividend = DIV_W'(r0);
        divisor  = r1;
      end
      default: begin
        dividend = DIV_W'(a_mag);
        divisor  = modulus;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MS_TQ: begin
        mx = t1;
        my = div_quot[MOD_BITS-1:0];
      end
      MS_AINV: begin
        mx = a_res;
        my = t1;
      end
      MS_ACC: begin
        mx = acc;
        my = base;
      end
      MS_SQ: begin
        mx = base;
        my = base;
      end
      default: begin
        mx = a_res;
        my = b_res;
      end
    endcase
  end

  mau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  mau_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .m     (modulus),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign a_from_rem = (a_raw[A_W-1] && div_rem != '0) ? modulus - div_rem : div_rem;

  assign sum     = {1'b0, a_res} + {1'b0, b_res};
  assign sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;

  always_comb begin
    case (op)
      OP_ADD:  simple = sum_red[MOD_BITS-1:0];
      OP_SUB:  simple = (a_res >= b_res) ? a_res - b_res : a_res + (modulus - b_res);
      OP_NEG:  simple = (a_res == '0) ? '0 : modulus - a_res;
      default: simple = a_res;
    endcase
  end

  assign t_new = (t0 >= mul_p) ? t0 - mul_p : t0 + (modulus - mul_p);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= req.operation;
      a_raw <= req.operand_a;
      braw  <= req.operand_b;
    end
    if (cmd.a_load) begin
      a_res <= a_from_rem;
    end
    if (cmd.b_load) begin
      b_res <= div_rem;
    end
    if (cmd.euc_init) begin
      r0 <= modulus;
      r1 <= b_res;
      t0 <= '0;
      t1 <= MOD_BITS'(1);
    end else if (cmd.euc_step) begin
      r0 <= r1;
      r1 <= rtmp;
      t0 <= t1;
      t1 <= t_new;
    end
    if (cmd.euc_rem) begin
      rtmp <= div_rem;
    end
    if (cmd.pow_init) begin
      acc  <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      base <= a_res;
      e    <= braw;
    end else begin
      if (cmd.acc_load) begin
        acc <= mul_p;
      end
      if (cmd.base_load) begin
        base <= mul_p;
        e    <= e >> 1;
      end
    end
    if (cmd.capture) begin
      res <= '0;
      err <= 1'b0;
    end else begin
      if (cmd.res_simple) res <= simple;
      if (cmd.res_inv) res <= t1;
      if (cmd.res_mul) res <= mul_p;
      if (cmd.pow_one) res <= MOD_BITS'(1);
      if (cmd.res_acc) res <= acc;
      if (cmd.err_set) err <= 1'b1;
    end
    if (cmd.out_load) begin
      rsp_q.result <= res;
      rsp_q.error  <= err;
    end
  end

  always_comb begin
    sts.m_zero    = modulus == '0;
    sts.div_done  = div_done;
    sts.mul_done  = mul_done;
    sts.op        = op;
    sts.braw_zero = braw == '0;
    sts.b_zero    = b_res == '0;
    sts.rtmp_zero = rtmp == '0;
    sts.r1_one    = r1 == MOD_BITS'(1);
    sts.e_bit0    = e[0];
    sts.e_last    = e[B_W-1:1] == '0;
  end

  assign rsp = rsp_q;

endmodule

// ----- design/mau_ctrl.sv -----
module mau_ctrl
  import mau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOAD   = 13'b0000000000010,
    S_RA     = 13'b0000000000100,
    S_RB     = 13'b0000000001000,
    S_DISP   = 13'b0000000010000,
    S_MUL    = 13'b0000000100000,
    S_ESTART = 13'b0000001000000,
    S_EDIV   = 13'b0000010000000,
    S_EMUL   = 13'b0000100000000,
    S_PSTEP  = 13'b0001000000000,
    S_PACC   = 13'b0010000000000,
    S_PSQ    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.m_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_A;
          state_next    = S_RA;
        end
      end
      S_RA: begin
        if (sts.div_done) begin
          cmd.a_load    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_B;
          state_next    = S_RB;
        end
      end
      S_RB: begin
        if (sts.div_done) begin
          cmd.b_load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          OP_ADD, OP_SUB, OP_NEG, OP_REDUCE: begin
            cmd.res_simple = 1'b1;
            state_next     = S_FIN;
          end
          OP_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_AB;
            state_next    = S_MUL;
          end
          OP_QUO, OP_RECIP: begin
            if (sts.b_zero) begin
              cmd.err_set = 1'b1;
              state_next  = S_FIN;
            end else begin
              cmd.euc_init = 1'b1;
              state_next   = S_ESTART;
            end
          end
          OP_POW: begin
            if (sts.braw_zero) begin
              cmd.pow_one = 1'b1;
              state_next  = S_FIN;
            end else begin
              cmd.pow_init = 1'b1;
              state_next   = S_PSTEP;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.res_mul = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_ESTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_EUC;
        state_next    = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_sel = DS_EUC;
        if (sts.div_done) begin
          cmd.euc_rem   = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_TQ;
          state_next    = S_EMUL;
        end
      end
      S_EMUL: begin
        if (sts.mul_done) begin
          if (!sts.rtmp_zero) begin
            cmd.euc_step = 1'b1;
            state_next   = S_ESTART;
          end else if (!sts.r1_one) begin
            cmd.err_set = 1'b1;
            state_next  = S_FIN;
          end else if (sts.op == OP_RECIP) begin
            cmd.res_inv = 1'b1;
            state_next  = S_FIN;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_AINV;
            state_next    = S_MUL;
          end
        end
      end
      S_PSTEP: begin
        cmd.mul_start = 1'b1;
        if (sts.e_bit0) begin
          cmd.mul_sel = MS_ACC;
          state_next  = S_PACC;
        end else begin
          cmd.mul_sel = MS_SQ;
          state_next  = S_PSQ;
        end
      end
      S_PACC: begin
        if (sts.mul_done) begin
          cmd.acc_load  = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_SQ;
          state_next    = S_PSQ;
        end
      end
      S_PSQ: begin
        if (sts.mul_done) begin
          cmd.base_load = 1'b1;
          if (sts.e_last) begin
            cmd.res_acc = 1'b1;
            state_next  = S_FIN;
          end else begin
            state_next = S_PSTEP;
          end
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign req_ready = state == S_IDLE;

endmodule

// ----- design/modular_arithmetic_unit_core.sv -----
// Channel   Handshake                  Payload       Width
// request   req_valid / req_ready      req (req_t)   3 + 28 + 27 bits
// response  rsp_valid / rsp_ready      rsp (rsp_t)   24 + 1 bits
// config    psel, penable, pwrite      pwdata        32 bits, modulus at byte 0
//
// Every request with a nonzero modulus first reduces both operands on the shared restoring
// divider, one pass each; add, subtract, negate and reduce then finish without further passes.
// Multiply adds one pass of the shift-add modular multiplier.
// Each reciprocal Euclid step runs the divider and then the multiplier; each step of a power
// runs a multiply when the exponent bit is set and then a squaring.
// Reset is synchronous; it returns the controller to idle and sets the modulus to 1.
// A finished result waits in the output register; the next request is taken meanwhile.
module modular_arithmetic_unit_core
  import mau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [MOD_BITS-1:0] modulus;
  cmd_t                cmd;
  sts_t                sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_MODULUS) begin
      modulus <= pwdata[MOD_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MODULUS) ? DATA_W'(modulus) : '0;

  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mau_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .modulus (modulus),
    .cmd     (cmd),
    .sts     (sts),
    .rsp     (rsp)
  );

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error |-> rsp.result == '0)
    else $error("error response carries a nonzero result");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in progress");

  assert property (@(posedge clk) disable iff (rst)
    !(sts.div_done && sts.mul_done))
    else $error("divider and multiplier finished together");

endmodule
